// ===== rtl/radix2_fft_multidim_defines.svh =====
// assertion macros shared by the fft rtl
// expects clk_i and rst_ni in the including module
`ifndef RADIX2_FFT_MULTIDIM_DEFINES_SVH
`define RADIX2_FFT_MULTIDIM_DEFINES_SVH
`define R2FFT_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define R2FFT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/r2fft_pkg.sv =====
// shared types, constants and helper functions of the multidimensional fft
// no dependencies
`default_nettype none
package r2fft_pkg;

  localparam int unsigned MAX_LOG2_POINTS = 12;
  localparam int unsigned AW = MAX_LOG2_POINTS;
  localparam int unsigned CW = MAX_LOG2_POINTS + 1;
  localparam int unsigned TW_ENTRIES = 1024;
  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_BAD_SIZE = 2'd2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  localparam logic [1:0] REG_INVERSE = 2'd0;
  localparam logic [1:0] REG_DIMS = 2'd1;
  localparam logic [1:0] REG_LOG2_SIDE = 2'd2;

  typedef logic [31:0] tw_rom_t [TW_ENTRIES];

  typedef enum logic [3:0] {
    ST_IDLE, ST_FETCH, ST_RD_A, ST_RD_B, ST_LAT_B,
    ST_MUL, ST_SUM, ST_WR_A, ST_WR_B, ST_NEXT
  } state_e;

  typedef enum logic [1:0] {PH_PRE, PH_REV, PH_STG, PH_POST} phase_e;

  localparam int unsigned SinDiv [6] = '{6, 20, 42, 72, 110, 156};
  localparam int unsigned CosDiv [7] = '{2, 12, 30, 56, 90, 132, 182};

  function automatic logic [15:0] q30_to_q15(longint v);
    longint r;
    begin
      if (v < 0) v = 0;
      r = (v + 16384) >>> 15;
      if (r > 32767) r = 32767;
      q30_to_q15 = r[15:0];
    end
  endfunction

  // {cos, sin} of (e*16)*pi/32768 for the first quadrant
  function automatic tw_rom_t build_twiddle_rom();
    tw_rom_t rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint sum;
    logic [15:0] sv;
    logic [15:0] cv;
    begin
      for (int e = 0; e < TW_ENTRIES; e++) begin
        x = (64'(e * 16) * PI_Q30) >> 15;
        x2 = (x * x) >> 30;
        term = x;
        sum = longint'(x);
        for (int i = 0; i < 6; i++) begin
          term = ((term * x2) >> 30) / 64'(SinDiv[i]);
          if ((i % 2) == 0) sum = sum - longint'(term);
          else sum = sum + longint'(term);
        end
        sv = q30_to_q15(sum);
        term = ONE_Q30;
        sum = longint'(ONE_Q30);
        for (int i = 0; i < 7; i++) begin
          term = ((term * x2) >> 30) / 64'(CosDiv[i]);
          if ((i % 2) == 0) sum = sum - longint'(term);
          else sum = sum + longint'(term);
        end
        cv = q30_to_q15(sum);
        rom[e] = {cv, sv};
      end
      build_twiddle_rom = rom;
    end
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [36:0] v);
    begin
      if (v > 37'sd2147483647) sat32 = 32'sh7fffffff;
      else if (v < -37'sd2147483648) sat32 = 32'sh80000000;
      else sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [31:0] neg_sat(logic signed [31:0] v);
    begin
      if (v == 32'sh80000000) neg_sat = 32'sh7fffffff;
      else neg_sat = -v;
    end
  endfunction

endpackage
`default_nettype wire

// ===== rtl/r2fft_ram.sv =====
// single write, single read synchronous memory with registered read data
// no dependencies
`default_nettype none
module r2fft_ram #(
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 64
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/r2fft_bfly.sv =====
// radix-2 butterfly datapath with twiddle rom, three register stages
// depends on r2fft_pkg
`default_nettype none
module r2fft_bfly (
  input  wire logic               clk_i,
  input  wire logic        [15:0] tw_phase_i,
  input  wire logic signed [31:0] a_re_i,
  input  wire logic signed [31:0] a_im_i,
  input  wire logic signed [31:0] b_re_i,
  input  wire logic signed [31:0] b_im_i,
  output logic signed      [31:0] sum_re_o,
  output logic signed      [31:0] sum_im_o,
  output logic signed      [31:0] dif_re_o,
  output logic signed      [31:0] dif_im_o
);

  localparam r2fft_pkg::tw_rom_t TwRom = r2fft_pkg::build_twiddle_rom();

  logic        [31:0] tw_q;
  logic        [1:0]  quad_q;
  logic signed [16:0] cs;
  logic signed [16:0] sn;
  logic signed [16:0] wr;
  logic signed [16:0] wi;
  logic signed [16:0] ws;
  logic signed [49:0] pr_d;
  logic signed [49:0] pi_d;
  logic signed [49:0] pr_q;
  logic signed [49:0] pi_q;
  logic signed [50:0] tr_full;
  logic signed [50:0] ti_full;
  logic signed [36:0] tr;
  logic signed [36:0] ti;

  always_ff @(posedge clk_i) begin
    tw_q <= TwRom[tw_phase_i[13:4]];
    quad_q <= tw_phase_i[15:14];
  end

  always_comb begin
    cs = 17'(signed'(tw_q[31:16]));
    ws = 17'(signed'(tw_q[15:0]));
    case (quad_q)
      2'd0: begin wr = cs; sn = ws; end
      2'd1: begin wr = -ws; sn = cs; end
      2'd2: begin wr = -cs; sn = -ws; end
      default: begin wr = ws; sn = -cs; end
    endcase
    wi = -sn;
    pr_d = 50'(b_re_i) * 50'(wr) - 50'(b_im_i) * 50'(wi);
    pi_d = 50'(b_re_i) * 50'(wi) + 50'(b_im_i) * 50'(wr);
    tr_full = (51'(pr_q) + 51'sd16384) >>> 15;
    ti_full = (51'(pi_q) + 51'sd16384) >>> 15;
    tr = tr_full[36:0];
    ti = ti_full[36:0];
  end

  always_ff @(posedge clk_i) begin
    pr_q <= pr_d;
    pi_q <= pi_d;
    sum_re_o <= r2fft_pkg::sat32(37'(a_re_i) + tr);
    sum_im_o <= r2fft_pkg::sat32(37'(a_im_i) + ti);
    dif_re_o <= r2fft_pkg::sat32(37'(a_re_i) - tr);
    dif_im_o <= r2fft_pkg::sat32(37'(a_im_i) - ti);
  end

endmodule
`default_nettype wire

// ===== rtl/radix2_fft_multidim.sv =====
// Load: one sample per cycle while no output word is waiting. Fetch: one result per request,
// with no new item taken until the fetch returns to idle. A full frame starts the in-place
// transform on every axis: a conjugate pass (inverse only), a bit-reversal pass, the butterfly
// stages and a conjugate-and-scale pass (inverse only); no items are taken meanwhile.
// Reset clears the control registers (forward, one dimension, side 64); memory and data registers are not cleared.
`default_nettype none
`include "radix2_fft_multidim_defines.svh"
module radix2_fft_multidim (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [3:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // sample_im, sample_re
  input  wire logic        s_axis_tuser,   // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [63:0] m_axis_tdata,   // result_im, result_re
  output logic             m_axis_tlast,   // last
  output logic      [1:0]  m_axis_tuser    // status
);

  localparam int unsigned AW = r2fft_pkg::AW;
  localparam int unsigned CW = r2fft_pkg::CW;

  r2fft_pkg::state_e state_q, state_d;
  r2fft_pkg::phase_e phase_q, phase_d;

  logic          inv_q;
  logic [1:0]    dims_q;
  logic [3:0]    ls_q;
  logic [CW-1:0] load_cnt_q, load_cnt_d;
  logic [CW-1:0] read_cnt_q, read_cnt_d;
  logic          ready_q, ready_d;
  logic [1:0]    axis_q, axis_d;
  logic [AW-1:0] line_q, line_d;
  logic [AW-1:0] j_q, j_d;
  logic [3:0]    m_q, m_d;
  logic signed [31:0] a_re_q, a_im_q, b_re_q, b_im_q;
  logic          m_valid_q, m_valid_d;
  logic [63:0]   m_data_q, m_data_d;
  logic          m_last_q, m_last_d;
  logic [1:0]    m_user_q, m_user_d;

  logic [1:0]    dims_eff;
  logic [5:0]    tot_log;
  logic          bad;
  logic [CW-1:0] total;
  logic [AW-1:0] n_m1;
  logic [AW-1:0] half_m1;
  logic [AW-1:0] lines_m1;
  logic [4:0]    sh_a;
  logic [AW-1:0] low_mask;
  logic [AW-1:0] line_base;
  logic [AW-1:0] half_m;
  logic [AW-1:0] hm1;
  logic [AW-1:0] kk;
  logic [AW-1:0] rev_full;
  logic [AW-1:0] ea, eb;
  logic [AW-1:0] addr_a, addr_b;
  logic [15:0]   tw_phase;
  logic          done;
  logic          in_acc, out_acc;
  logic [CW-1:0] ld_idx, ld_next, rd_next;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [63:0]   mem_wdata, mem_rdata;
  logic signed [31:0] sum_re, sum_im, dif_re, dif_im;
  logic signed [31:0] ca_im;

  r2fft_ram #(.ADDR_W(AW), .DATA_W(64)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  r2fft_bfly u_bfly (
    .clk_i      (clk_i),
    .tw_phase_i (tw_phase),
    .a_re_i     (a_re_q),
    .a_im_i     (a_im_q),
    .b_re_i     (b_re_q),
    .b_im_i     (b_im_q),
    .sum_re_o   (sum_re),
    .sum_im_o   (sum_im),
    .dif_re_o   (dif_re),
    .dif_im_o   (dif_im)
  );

  // frame geometry, element addresses and twiddle phase
  always_comb begin
    dims_eff = (dims_q == 2'd0) ? 2'd1 : dims_q;
    unique case (dims_eff)
      2'd3: tot_log = {2'b0, ls_q} + {1'b0, ls_q, 1'b0};
      2'd2: tot_log = {1'b0, ls_q, 1'b0};
      default: tot_log = {2'b0, ls_q};
    endcase
    bad = tot_log > 6'(r2fft_pkg::MAX_LOG2_POINTS);
    total = bad ? '0 : (CW'(1) << tot_log[3:0]);
    n_m1 = AW'((CW'(1) << ls_q) - CW'(1));
    half_m1 = AW'(((CW'(1) << ls_q) >> 1) - CW'(1));
    lines_m1 = AW'((CW'(1) << (tot_log[3:0] - ls_q)) - CW'(1));
    sh_a = (axis_q == 2'd0) ? 5'd0 : (axis_q == 2'd1) ? {1'b0, ls_q} : {ls_q, 1'b0};
    low_mask = AW'((CW'(1) << sh_a) - CW'(1));
    line_base = (line_q & low_mask) | AW'((line_q >> sh_a) << (6'(sh_a) + 6'(ls_q)));
    half_m = AW'(1) << (m_q - 4'd1);
    hm1 = half_m - AW'(1);
    kk = j_q & hm1;
    for (int b = 0; b < AW; b++) rev_full[b] = j_q[AW-1-b];
    unique case (phase_q)
      r2fft_pkg::PH_REV: begin
        ea = j_q;
        eb = rev_full >> (4'(AW) - ls_q);
      end
      r2fft_pkg::PH_STG: begin
        ea = ((j_q & ~hm1) << 1) | kk;
        eb = (((j_q & ~hm1) << 1) | kk) | half_m;
      end
      default: begin
        ea = j_q;
        eb = j_q;
      end
    endcase
    addr_a = line_base | AW'(ea << sh_a);
    addr_b = line_base | AW'(eb << sh_a);
    tw_phase = 16'({4'b0, kk} << (5'd16 - 5'(m_q)));
  end

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_valid_q && m_axis_tready;
  assign s_axis_tready = (state_q == r2fft_pkg::ST_IDLE) && (!m_valid_q || m_axis_tready);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata = m_data_q;
  assign m_axis_tlast = m_last_q;
  assign m_axis_tuser = m_user_q;
  assign ca_im = r2fft_pkg::neg_sat(a_im_q);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    load_cnt_d = load_cnt_q;
    read_cnt_d = read_cnt_q;
    ready_d = ready_q;
    axis_d = axis_q;
    line_d = line_q;
    j_d = j_q;
    m_d = m_q;
    m_valid_d = out_acc ? 1'b0 : m_valid_q;
    m_data_d = m_data_q;
    m_last_d = m_last_q;
    m_user_d = m_user_q;
    mem_we = 1'b0;
    mem_waddr = addr_a;
    mem_wdata = {b_im_q, b_re_q};
    mem_raddr = addr_a;
    done = 1'b0;
    ld_idx = (ready_q || load_cnt_q >= total) ? '0 : load_cnt_q;
    ld_next = ld_idx + CW'(1);
    rd_next = read_cnt_q + CW'(1);

    unique case (state_q)
      r2fft_pkg::ST_IDLE: begin
        mem_raddr = read_cnt_q[AW-1:0];
        if (in_acc) begin
          if (s_axis_tuser == r2fft_pkg::CMD_LOAD) begin
            if (!bad) begin
              mem_we = 1'b1;
              mem_waddr = ld_idx[AW-1:0];
              mem_wdata = {{16{s_axis_tdata[31]}}, s_axis_tdata[31:16],
                           {16{s_axis_tdata[15]}}, s_axis_tdata[15:0]};
              if (ready_q) begin
                ready_d = 1'b0;
                read_cnt_d = '0;
              end
              if (ld_next == total) begin
                load_cnt_d = '0;
                axis_d = '0;
                line_d = '0;
                j_d = '0;
                m_d = 4'd1;
                phase_d = inv_q ? r2fft_pkg::PH_PRE : r2fft_pkg::PH_REV;
                state_d = r2fft_pkg::ST_RD_A;
              end else begin
                load_cnt_d = ld_next;
              end
            end
          end else if (bad) begin
            m_valid_d = 1'b1;
            m_data_d = '0;
            m_last_d = 1'b0;
            m_user_d = r2fft_pkg::STATUS_BAD_SIZE;
          end else if (!ready_q || read_cnt_q >= total) begin
            m_valid_d = 1'b1;
            m_data_d = '0;
            m_last_d = 1'b0;
            m_user_d = r2fft_pkg::STATUS_EMPTY;
          end else begin
            state_d = r2fft_pkg::ST_FETCH;
          end
        end
      end
      r2fft_pkg::ST_FETCH: begin
        m_valid_d = 1'b1;
        m_data_d = mem_rdata;
        m_user_d = r2fft_pkg::STATUS_OK;
        m_last_d = (rd_next == total);
        if (rd_next == total) begin
          ready_d = 1'b0;
          read_cnt_d = '0;
        end else begin
          read_cnt_d = rd_next;
        end
        state_d = r2fft_pkg::ST_IDLE;
      end
      r2fft_pkg::ST_RD_A: begin
        if (phase_q == r2fft_pkg::PH_REV && eb <= ea) state_d = r2fft_pkg::ST_NEXT;
        else state_d = r2fft_pkg::ST_RD_B;
      end
      r2fft_pkg::ST_RD_B: begin
        mem_raddr = addr_b;
        state_d = r2fft_pkg::ST_LAT_B;
      end
      r2fft_pkg::ST_LAT_B: begin
        state_d = (phase_q == r2fft_pkg::PH_STG) ? r2fft_pkg::ST_MUL : r2fft_pkg::ST_WR_A;
      end
      r2fft_pkg::ST_MUL: state_d = r2fft_pkg::ST_SUM;
      r2fft_pkg::ST_SUM: state_d = r2fft_pkg::ST_WR_A;
      r2fft_pkg::ST_WR_A: begin
        mem_we = 1'b1;
        mem_waddr = addr_a;
        unique case (phase_q)
          r2fft_pkg::PH_PRE: mem_wdata = {ca_im, a_re_q};
          r2fft_pkg::PH_REV: mem_wdata = {b_im_q, b_re_q};
          r2fft_pkg::PH_STG: mem_wdata = {sum_im, sum_re};
          default: mem_wdata = {ca_im >>> ls_q, a_re_q >>> ls_q};
        endcase
        state_d = (phase_q == r2fft_pkg::PH_REV || phase_q == r2fft_pkg::PH_STG) ?
                  r2fft_pkg::ST_WR_B : r2fft_pkg::ST_NEXT;
      end
      r2fft_pkg::ST_WR_B: begin
        mem_we = 1'b1;
        mem_waddr = addr_b;
        mem_wdata = (phase_q == r2fft_pkg::PH_STG) ? {dif_im, dif_re} : {a_im_q, a_re_q};
        state_d = r2fft_pkg::ST_NEXT;
      end
      r2fft_pkg::ST_NEXT: begin
        logic line_end;
        line_end = 1'b0;
        state_d = r2fft_pkg::ST_RD_A;
        j_d = j_q + AW'(1);
        unique case (phase_q)
          r2fft_pkg::PH_PRE: begin
            if (j_q == n_m1) begin
              j_d = '0;
              phase_d = r2fft_pkg::PH_REV;
            end
          end
          r2fft_pkg::PH_REV: begin
            if (j_q == n_m1) begin
              j_d = '0;
              m_d = 4'd1;
              if (ls_q != 4'd0) phase_d = r2fft_pkg::PH_STG;
              else if (inv_q) phase_d = r2fft_pkg::PH_POST;
              else line_end = 1'b1;
            end
          end
          r2fft_pkg::PH_STG: begin
            if (j_q == half_m1) begin
              j_d = '0;
              if (m_q == ls_q) begin
                if (inv_q) phase_d = r2fft_pkg::PH_POST;
                else line_end = 1'b1;
              end else begin
                m_d = m_q + 4'd1;
              end
            end
          end
          default: begin
            if (j_q == n_m1) begin
              j_d = '0;
              line_end = 1'b1;
            end
          end
        endcase
        if (line_end) begin
          phase_d = inv_q ? r2fft_pkg::PH_PRE : r2fft_pkg::PH_REV;
          m_d = 4'd1;
          if (line_q == lines_m1) begin
            line_d = '0;
            if (axis_q == dims_eff - 2'd1) begin
              done = 1'b1;
              ready_d = 1'b1;
              read_cnt_d = '0;
              state_d = r2fft_pkg::ST_IDLE;
            end else begin
              axis_d = axis_q + 2'd1;
            end
          end else begin
            line_d = line_q + AW'(1);
          end
        end
      end
      default: state_d = r2fft_pkg::ST_IDLE;
    endcase

    if (cfg_we_i && (cfg_idx_i inside {r2fft_pkg::REG_INVERSE, r2fft_pkg::REG_DIMS,
                                       r2fft_pkg::REG_LOG2_SIDE})) begin
      load_cnt_d = '0;
      read_cnt_d = '0;
      ready_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= r2fft_pkg::ST_IDLE;
      phase_q <= r2fft_pkg::PH_REV;
      inv_q <= 1'b0;
      dims_q <= 2'd1;
      ls_q <= 4'd6;
      load_cnt_q <= '0;
      read_cnt_q <= '0;
      ready_q <= 1'b0;
      axis_q <= '0;
      line_q <= '0;
      j_q <= '0;
      m_q <= 4'd1;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      load_cnt_q <= load_cnt_d;
      read_cnt_q <= read_cnt_d;
      ready_q <= ready_d;
      axis_q <= axis_d;
      line_q <= line_d;
      j_q <= j_d;
      m_q <= m_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          r2fft_pkg::REG_INVERSE: inv_q <= cfg_data_i[0];
          r2fft_pkg::REG_DIMS: dims_q <= cfg_data_i[1:0];
          r2fft_pkg::REG_LOG2_SIDE: ls_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_last_q <= m_last_d;
    m_user_q <= m_user_d;
    if (state_q == r2fft_pkg::ST_RD_B) begin
      a_re_q <= signed'(mem_rdata[31:0]);
      a_im_q <= signed'(mem_rdata[63:32]);
    end
    if (state_q == r2fft_pkg::ST_LAT_B) begin
      b_re_q <= signed'(mem_rdata[31:0]);
      b_im_q <= signed'(mem_rdata[63:32]);
    end
  end

  `R2FFT_ASSERT_IMPL(a_busy_no_accept, state_q != r2fft_pkg::ST_IDLE, !s_axis_tready,
                     "item accepted during transform or fetch")
  `R2FFT_ASSERT_IMPL(a_fetch_slot_free, state_q == r2fft_pkg::ST_FETCH, !m_valid_q,
                     "fetch data would overwrite a pending word")
  `R2FFT_ASSERT_IMPL(a_no_ready_in_run, state_q == r2fft_pkg::ST_RD_A, !ready_q,
                     "results flagged ready while transform runs")
  `R2FFT_ASSERT_NEXT(a_done_sets_ready, done && !cfg_we_i, ready_q,
                     "transform finished without results ready")

endmodule
`default_nettype wire
